@@ design/pcd_pkg.sv @@
// ============================================================================
// pcd_pkg: shared types and constants of the PWM CO2 period decoder
// Field widths, register indexes, reset values, phase codes and the LED bar
// pattern lookup.
// ============================================================================
`default_nettype none

package pcd_pkg;

    // Field widths
    localparam int PIN_W       = 1;
    localparam int PHASE_W     = 3;
    localparam int PPM_W       = 16;
    localparam int BAR_W       = 4;
    localparam int PERIOD_W    = 12;
    localparam int SCALE_W     = 14;
    localparam int BASE_W      = 16;
    localparam int STEP_W      = 14;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    // base + 5 * step never exceeds 18 bits
    localparam int BOUND_W     = 18;
    localparam int BAND_IDX_W  = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_STEP  = 3'd4;

    // Register reset values
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 12'd800;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 12'd1200;
    localparam logic [SCALE_W-1:0]  FULL_SCALE_RST = 14'd2000;
    localparam logic [BASE_W-1:0]   BAND_BASE_RST  = 16'd400;
    localparam logic [STEP_W-1:0]   BAND_STEP_RST  = 14'd200;

    // Measurement phases
    localparam logic [PHASE_W-1:0] PH_START     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT_LOW  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_HIGH = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CNT_HIGH  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CNT_LOW   = 3'd4;

    // Last band index (red only)
    localparam logic [BAND_IDX_W-1:0] BAND_LAST = 3'd6;

    // Divider result handed back to the sequencer
    typedef struct packed {
        logic             done;
        logic [PPM_W-1:0] quot;
    } t_div_result;

    // LED bar lamp pattern of band k
    function automatic logic [BAR_W-1:0] bar_pattern(input logic [BAND_IDX_W-1:0] k);
        logic [BAR_W-1:0] p;
        unique case (k)
            3'd0:    p = 4'h1;
            3'd1:    p = 4'h3;
            3'd2:    p = 4'h2;
            3'd3:    p = 4'h6;
            3'd4:    p = 4'h4;
            3'd5:    p = 4'hC;
            default: p = 4'h8;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ design/pcd_in_if.sv @@
// ============================================================================
// pcd_in_if: sample channel
// One beat carries the sensor pin level sampled at one millisecond tick.
// ============================================================================
`default_nettype none

interface pcd_in_if;
    logic                        valid;
    logic                        ready;
    logic [pcd_pkg::PIN_W-1:0]   pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

@@ design/pcd_out_if.sv @@
// ============================================================================
// pcd_out_if: result channel
// One beat per tick: phase, outcome flags, concentration and LED state.
// ============================================================================
`default_nettype none

interface pcd_out_if;
    logic                          valid;
    logic                          ready;
    logic [pcd_pkg::PHASE_W-1:0]   phase;
    logic                          done_res;
    logic                          error;
    logic [pcd_pkg::PPM_W-1:0]     ppm;
    logic [pcd_pkg::BAR_W-1:0]     bar_leds;
    logic                          error_led;

    modport source (output valid, output phase, output done_res, output error,
                    output ppm, output bar_leds, output error_led, input ready);
    modport sink   (input valid, input phase, input done_res, input error,
                    input ppm, input bar_leds, input error_led, output ready);
endinterface

`default_nettype wire

@@ design/pcd_divider.sv @@
// ============================================================================
// pcd_divider: saturating restoring divider
// Returns min(num / den, 65535), one quotient bit per cycle.
// ============================================================================
`default_nettype none

module pcd_divider #(
    parameter int CW = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pcd_pkg::SCALE_W+CW-1:0] i_num,
    input  wire logic [CW:0]                   i_den,
    output pcd_pkg::t_div_result               o_res
);

    localparam int QW    = pcd_pkg::PPM_W;
    localparam int NW    = pcd_pkg::SCALE_W + CW;
    localparam int DW    = CW + 1;
    localparam int XW    = DW + QW;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [QW-1:0]    r_low;

    logic             w_sat;
    logic [DW:0]      w_trial;
    logic [DW-1:0]    n_rem;
    logic             n_qbit;

    // quotient overflows 16 bits exactly when num >= den * 2^16
    assign w_sat = XW'(i_num) >= {i_den, {QW{1'b0}}};

    always_comb begin
        w_trial = {r_rem, r_low[QW-1]};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem  = DW'(w_trial - {1'b0, r_den});
            n_qbit = 1'b1;
        end else begin
            n_rem  = DW'(w_trial);
            n_qbit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (w_sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // upper numerator bits are below den, so they seed the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_num[NW-1:QW]);
            r_den <= i_den;
            r_low <= w_sat ? {QW{1'b1}} : i_num[QW-1:0];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[QW-2:0], n_qbit};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_low;

endmodule

`default_nettype wire

@@ design/pwm_co2_period_decoder_unit.sv @@
// ============================================================================
// pwm_co2_period_decoder_unit: PWM CO2 sensor period decoder with LED bar
// Measures high and low time of the sensor PWM output, converts a valid
// period to ppm and drives a seven-band four-LED bar plus an error LED.
// ============================================================================
// Usage:
//   i_in carries one beat per millisecond tick with the sampled pin level.
//   o_out returns exactly one beat per input beat: the phase after the tick,
//   done/error flags of this tick, last ppm, bar LEDs and the error LED.
//   Registers (min_period, max_period, full_scale, band_base, band_step) are
//   written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so only
//   while the block is idle, which the block itself does not enforce.
// Processing:
//   An ordinary tick writes its result beat into the output register on
//   acceptance, so ordinary ticks can follow one per cycle while beats drain.
//   A tick that completes a period runs the multiplier, a divider start step,
//   the serial divider (which develops the quotient bit by bit and hands it
//   back; a saturating quotient skips the bit loop) and the band search (one
//   boundary per cycle through one adder/comparator). A short high time or a
//   nonpositive divisor skips the divider. One tick is in flight at a time.
// Reset: synchronous, active low. Registers return to their defaults, phase
//   returns to start, counts, ppm, bar and error LED clear.
// Stall: a result beat is held in the output register until taken; the next
//   tick is accepted in the same cycle that the pending beat drains.
// ============================================================================
`default_nettype none

module pwm_co2_period_decoder_unit #(
    parameter int COUNT_WIDTH = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pcd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    pcd_in_if.sink                                 i_in,
    pcd_out_if.source                              o_out
);

    localparam int CW   = COUNT_WIDTH;
    localparam int CMPW = (CW > pcd_pkg::PERIOD_W) ? CW : pcd_pkg::PERIOD_W;
    localparam int SW   = (CW + 1 > pcd_pkg::PERIOD_W) ? CW + 1 : pcd_pkg::PERIOD_W;
    localparam int NW   = pcd_pkg::SCALE_W + CW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_BAND  = 5'b10000
    } t_seq_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pcd_pkg::PERIOD_W-1:0] r_min_period;
    logic [pcd_pkg::PERIOD_W-1:0] r_max_period;
    logic [pcd_pkg::SCALE_W-1:0]  r_full_scale;
    logic [pcd_pkg::BASE_W-1:0]   r_band_base;
    logic [pcd_pkg::STEP_W-1:0]   r_band_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= pcd_pkg::MIN_PERIOD_RST;
            r_max_period <= pcd_pkg::MAX_PERIOD_RST;
            r_full_scale <= pcd_pkg::FULL_SCALE_RST;
            r_band_base  <= pcd_pkg::BAND_BASE_RST;
            r_band_step  <= pcd_pkg::BAND_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcd_pkg::REG_MIN_PERIOD: r_min_period <= i_cfg_data[pcd_pkg::PERIOD_W-1:0];
                pcd_pkg::REG_MAX_PERIOD: r_max_period <= i_cfg_data[pcd_pkg::PERIOD_W-1:0];
                pcd_pkg::REG_FULL_SCALE: r_full_scale <= i_cfg_data[pcd_pkg::SCALE_W-1:0];
                pcd_pkg::REG_BAND_BASE:  r_band_base  <= i_cfg_data[pcd_pkg::BASE_W-1:0];
                pcd_pkg::REG_BAND_STEP:  r_band_step  <= i_cfg_data[pcd_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Measurement state
    // ------------------------------------------------------------------
    t_seq_state                      r_state;
    logic [pcd_pkg::PHASE_W-1:0]     r_phase;
    logic [CW-1:0]                   r_high_cnt;
    logic [CW-1:0]                   r_low_cnt;
    logic [pcd_pkg::PPM_W-1:0]       r_ppm;
    logic [pcd_pkg::BAR_W-1:0]       r_bar;
    logic                            r_err_led;
    logic                            r_out_valid;
    logic                            r_done_flag;
    logic                            r_err_flag;

    // multiply, divide and band search operands
    logic [NW-1:0]                   r_prod;
    logic [CW:0]                     r_den;
    logic [pcd_pkg::BOUND_W-1:0]     r_bound;
    logic [pcd_pkg::BAND_IDX_W-1:0]  r_band_k;

    logic                            w_in_fire;
    logic                            w_out_fire;
    logic                            w_div_start;
    pcd_pkg::t_div_result            w_div_res;

    logic [pcd_pkg::PHASE_W-1:0]     n_phase;
    logic [CW-1:0]                   n_high_cnt;
    logic [CW-1:0]                   n_low_cnt;
    logic                            n_done;
    logic                            n_err;
    logic [SW-1:0]                   w_sum;
    logic [CW:0]                     w_cnt_sum;
    logic                            w_band_hit;

    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_out_fire  = r_out_valid && o_out.ready;
    assign w_div_start = (r_state == S_START);

    // Phase machine for one tick; start phase is folded into wait-low.
    always_comb begin
        n_phase    = r_phase;
        n_high_cnt = r_high_cnt;
        n_low_cnt  = r_low_cnt;
        n_done     = 1'b0;
        n_err      = 1'b0;
        w_sum      = '0;
        if (r_phase == pcd_pkg::PH_START || r_phase > pcd_pkg::PH_CNT_LOW) begin
            n_high_cnt = '0;
            n_low_cnt  = '0;
            n_phase    = pcd_pkg::PH_WAIT_LOW;
        end
        unique case (n_phase)
            pcd_pkg::PH_WAIT_LOW: begin
                if (!i_in.pin_level) begin
                    n_low_cnt = '0;
                    n_phase   = pcd_pkg::PH_WAIT_HIGH;
                end else begin
                    n_low_cnt = n_low_cnt + 1'b1;
                    n_err     = CMPW'(n_low_cnt) >= CMPW'(r_max_period);
                end
            end
            pcd_pkg::PH_WAIT_HIGH: begin
                if (i_in.pin_level) begin
                    n_high_cnt = '0;
                    n_phase    = pcd_pkg::PH_CNT_HIGH;
                end else begin
                    n_high_cnt = n_high_cnt + 1'b1;
                    n_err      = CMPW'(n_high_cnt) >= CMPW'(r_max_period);
                end
            end
            pcd_pkg::PH_CNT_HIGH: begin
                n_high_cnt = n_high_cnt + 1'b1;
                if (CMPW'(n_high_cnt) >= CMPW'(r_max_period)) begin
                    n_err = 1'b1;
                end else if (!i_in.pin_level) begin
                    n_phase = pcd_pkg::PH_CNT_LOW;
                end
            end
            default: begin
                n_low_cnt = n_low_cnt + 1'b1;
                if (CMPW'(n_low_cnt) >= CMPW'(r_max_period)) begin
                    n_err = 1'b1;
                end else if (i_in.pin_level) begin
                    // period window is open on both ends
                    w_sum = SW'({1'b0, n_high_cnt} + {1'b0, n_low_cnt});
                    if (SW'(r_min_period) < w_sum && w_sum < SW'(r_max_period)) begin
                        n_done = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
            end
        endcase
        if (n_err || n_done) begin
            n_phase = pcd_pkg::PH_START;
        end
    end

    assign w_cnt_sum  = {1'b0, r_high_cnt} + {1'b0, r_low_cnt};
    assign w_band_hit = (r_band_k == pcd_pkg::BAND_LAST) ||
                        (pcd_pkg::BOUND_W'(r_ppm) < r_bound);

    // ------------------------------------------------------------------
    // Sequencer: tick update, then multiply, divide and band search
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= pcd_pkg::PH_START;
            r_high_cnt  <= '0;
            r_low_cnt   <= '0;
            r_ppm       <= '0;
            r_bar       <= '0;
            r_err_led   <= 1'b0;
            r_out_valid <= 1'b0;
            r_done_flag <= 1'b0;
            r_err_flag  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_phase     <= n_phase;
                        r_high_cnt  <= n_high_cnt;
                        r_low_cnt   <= n_low_cnt;
                        r_done_flag <= n_done;
                        r_err_flag  <= n_err;
                        // any pending beat drains in this same cycle
                        r_out_valid <= !n_done;
                        if (n_done) begin
                            r_state <= S_MUL;
                        end else if (n_err) begin
                            r_bar     <= '0;
                            r_err_led <= 1'b1;
                        end
                    end else if (w_out_fire) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_MUL: begin
                    // short high time and nonpositive divisor skip the divider
                    if (r_high_cnt < CW'(2)) begin
                        r_ppm   <= '0;
                        r_state <= S_BAND;
                    end else if (w_cnt_sum <= (CW+1)'(4)) begin
                        r_ppm   <= '1;
                        r_state <= S_BAND;
                    end else begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_res.done) begin
                        r_ppm   <= w_div_res.quot;
                        r_state <= S_BAND;
                    end
                end
                S_BAND: begin
                    if (w_band_hit) begin
                        r_bar       <= pcd_pkg::bar_pattern(r_band_k);
                        r_err_led   <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Operand registers; load the first band boundary on entry to the search.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod   <= NW'(r_full_scale) * NW'(r_high_cnt - CW'(2));
            r_den    <= w_cnt_sum - (CW+1)'(4);
            r_bound  <= pcd_pkg::BOUND_W'(r_band_base);
            r_band_k <= '0;
        end else if (r_state == S_BAND) begin
            r_bound  <= r_bound + pcd_pkg::BOUND_W'(r_band_step);
            r_band_k <= r_band_k + 1'b1;
        end
    end

    pcd_divider #(
        .CW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_res   (w_div_res)
    );

    // ------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------
    assign o_out.valid     = r_out_valid;
    assign o_out.phase     = r_phase;
    assign o_out.done_res  = r_done_flag;
    assign o_out.error     = r_err_flag;
    assign o_out.ppm       = r_ppm;
    assign o_out.bar_leds  = r_bar;
    assign o_out.error_led = r_err_led;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !(r_out_valid && !o_out.ready))
        else $error("tick accepted while a result beat is stalled");

    a_beat_only_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_IDLE))
        else $error("result beat pending while sequencer busy");

    a_done_xor_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_done_flag && r_err_flag))
        else $error("tick flagged both done and error");

    a_error_clears_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_err_flag) |-> (r_bar == '0 && r_err_led &&
                                          r_phase == pcd_pkg::PH_START))
        else $error("error beat without cleared bar and lit error LED");

    a_div_start_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_res.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

endmodule

`default_nettype wire
